/* hdl/des_pkg.sv */
// shared types, tables and round functions for the des block cipher
package des_pkg;

   localparam int BlockW   = 64;
   localparam int HalfW    = 32;
   localparam int SubkeyW  = 48;
   localparam int CdW      = 56;
   localparam int Rounds   = 16;
   localparam int CsrAddrW = 4;
   localparam int CsrDataW = 64;

   typedef logic [BlockW-1:0]  block_type;
   typedef logic [HalfW-1:0]   half_type;
   typedef logic [SubkeyW-1:0] subkey_type;
   typedef logic [CdW-1:0]     cd_type;

   // register byte addresses
   localparam logic [CsrAddrW-1:0] AddrCipherKey   = 4'h0;
   localparam logic [CsrAddrW-1:0] AddrDecryptMode = 4'h8;

   typedef logic [6:0] tab_entry_type;

   localparam tab_entry_type TabIp [64] = '{
      58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
      62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
      57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

   localparam tab_entry_type TabFp [64] = '{
      40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
      38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
      36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

   localparam tab_entry_type TabE [48] = '{
      32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
      16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};

   localparam tab_entry_type TabP [32] = '{
      16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

   localparam tab_entry_type TabPc1 [56] = '{
      57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
      10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
      63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
      14,6,61,53,45,37,29, 21,13,5,28,20,12,4};

   localparam tab_entry_type TabPc2 [48] = '{
      14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
      41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};

   localparam logic [1:0] TabShift [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

   localparam logic [3:0] Sbox [8][64] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
        0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
        15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
        3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
        13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
        13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
        1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
        13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
        3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
        14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
        11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
        10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
        4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
        13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
        6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
        1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
        2,1,14,7,4,10,8,13,15,12,9,0,5,6,11,3}};

   function automatic block_type perm_ip(block_type x);
      block_type r;
      for (int i = 0; i < 64; i++) r[63-i] = x[64-int'(TabIp[i])];
      return r;
   endfunction

   function automatic block_type perm_fp(block_type x);
      block_type r;
      for (int i = 0; i < 64; i++) r[63-i] = x[64-int'(TabFp[i])];
      return r;
   endfunction

   function automatic cd_type perm_pc1(block_type x);
      cd_type r;
      for (int i = 0; i < 56; i++) r[55-i] = x[64-int'(TabPc1[i])];
      return r;
   endfunction

   function automatic subkey_type perm_pc2(cd_type x);
      subkey_type r;
      for (int i = 0; i < 48; i++) r[47-i] = x[56-int'(TabPc2[i])];
      return r;
   endfunction

   function automatic cd_type rot_cd(cd_type x, logic [1:0] n);
      logic [27:0] c;
      logic [27:0] d;
      c = x[55:28];
      d = x[27:0];
      if (n == 2'd2) begin
         c = {c[25:0], c[27:26]};
         d = {d[25:0], d[27:26]};
      end else begin
         c = {c[26:0], c[27]};
         d = {d[26:0], d[27]};
      end
      return {c, d};
   endfunction

   // feistel function f(r, k)
   function automatic half_type round_f(half_type h, subkey_type k);
      subkey_type x;
      half_type s;
      half_type p;
      logic [5:0] ch;
      for (int i = 0; i < 48; i++) x[47-i] = h[32-int'(TabE[i])];
      x = x ^ k;
      for (int n = 0; n < 8; n++) begin
         ch = x[47-6*n -: 6];
         s[31-4*n -: 4] = Sbox[n][{ch[5], ch[0], ch[4:1]}];
      end
      for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(TabP[i])];
      return p;
   endfunction

endpackage

/* hdl/des_stream_if.sv */
// valid/ready channels carrying one 64-bit input block and one 64-bit result block
interface des_req_if;
   logic               valid;
   logic               ready;
   des_pkg::block_type data_block;
   modport source (output valid, output data_block, input ready);
   modport sink (input valid, input data_block, output ready);
endinterface

interface des_rsp_if;
   logic               valid;
   logic               ready;
   des_pkg::block_type result_block;
   modport source (output valid, output result_block, input ready);
   modport sink (input valid, input result_block, output ready);
endinterface

/* hdl/des_block_cipher.sv */
// des ecb cipher: csr port, key schedule, 16-stage round pipeline, output register
//
//  channel | direction | transaction
//  req     | in        | data_block (64 bits), valid/ready
//  rsp     | out       | result_block (64 bits), valid/ready
//  csr     | in        | apb write/read of cipher_key (0x0) and decrypt_mode (0x8)
//
// one block per cycle while the output is not stalled; one stage per round plus output register.
// subkeys are computed from the key register combinationally and held static.
// the whole pipeline advances only when the output stage is free or being taken,
// so a stall freezes every stage and nothing is lost or repeated.
// reset clears valid bits, key and mode.
module des_block_cipher (
   input  logic                          clock,
   input  logic                          reset,
   des_req_if.sink                       req,
   des_rsp_if.source                     rsp,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [des_pkg::CsrAddrW-1:0]  csr_paddr,
   input  logic [des_pkg::CsrDataW-1:0]  csr_pwdata,
   output logic [des_pkg::CsrDataW-1:0]  csr_prdata,
   output logic                          csr_pready
);
   import des_pkg::*;

   block_type  key_ff, key_in;
   logic       mode_ff, mode_in;
   subkey_type sk [Rounds];
   cd_type     cd [Rounds+1];

   logic       vld_ff [Rounds+1];
   logic       vld_in [Rounds+1];
   half_type   l_ff [Rounds], l_in [Rounds];
   half_type   r_ff [Rounds], r_in [Rounds];
   block_type  out_ff, out_in;
   logic       adv;

   assign csr_pready = 1'b1;

   always_comb begin
      key_in  = key_ff;
      mode_in = mode_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr)
            AddrCipherKey:   key_in  = csr_pwdata;
            AddrDecryptMode: mode_in = csr_pwdata[0];
            default: ;
         endcase
      end
      case (csr_paddr)
         AddrCipherKey:   csr_prdata = key_ff;
         AddrDecryptMode: csr_prdata = {{(CsrDataW-1){1'b0}}, mode_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // key schedule
   always_comb begin
      cd[0] = perm_pc1(key_ff);
      for (int i = 0; i < Rounds; i++) begin
         cd[i+1] = rot_cd(cd[i], TabShift[i]);
         sk[i]   = perm_pc2(cd[i+1]);
      end
   end

   // stage i holds the result of round i; last slot is the output register
   assign adv       = !vld_ff[Rounds] || rsp.ready;
   assign req.ready = adv;
   assign rsp.valid = vld_ff[Rounds];
   assign rsp.result_block = out_ff;

   always_comb begin
      block_type ipb;
      subkey_type k;
      ipb = perm_ip(req.data_block);
      for (int i = 0; i < Rounds; i++) begin
         k = mode_ff ? sk[Rounds-1-i] : sk[i];
         if (i == 0) begin
            l_in[i]   = ipb[31:0];
            r_in[i]   = ipb[63:32] ^ round_f(ipb[31:0], k);
            vld_in[i] = req.valid;
         end else begin
            l_in[i]   = r_ff[i-1];
            r_in[i]   = l_ff[i-1] ^ round_f(r_ff[i-1], k);
            vld_in[i] = vld_ff[i-1];
         end
      end
      vld_in[Rounds] = vld_ff[Rounds-1];
      out_in = perm_fp({r_ff[Rounds-1], l_ff[Rounds-1]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         mode_ff <= 1'b0;
         for (int i = 0; i <= Rounds; i++) vld_ff[i] <= 1'b0;
      end else begin
         key_ff  <= key_in;
         mode_ff <= mode_in;
         if (adv) begin
            for (int i = 0; i <= Rounds; i++) vld_ff[i] <= vld_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < Rounds; i++) begin
            l_ff[i] <= l_in[i];
            r_ff[i] <= r_in[i];
         end
         out_ff <= out_in;
      end
   end

endmodule
